>>> hw/rtl/sida_pkg.sv
// ----------------------------------------------------------------------------
// sida_pkg
// Shared constants, types and helpers for the signed integer to decimal
// ASCII converter.
// ----------------------------------------------------------------------------
package sida_pkg;

  // Default width of the converted integer
  localparam int VALUE_BITS_DEF = 32;

  // ASCII codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Decimal digits needed for the largest magnitude, 2^(bits-1).
  // 1233/4096 approximates log10(2) closely enough up to 64 bits.
  function automatic int sida_num_digits(input int bits);
    return (((bits - 1) * 1233) >> 12) + 1;
  endfunction

  // Control word from the sequencer to the digit register
  typedef struct packed {
    logic clear;   // zero all digits
    logic dabble;  // adjust digits and shift one magnitude bit in
    logic bit_in;  // magnitude bit, most significant first
    logic drop;    // shift out the top digit
  } sida_ctl_t;

endpackage

>>> hw/rtl/sida_dabble.sv
// ----------------------------------------------------------------------------
// sida_dabble
// BCD digit register. Builds decimal digits one binary bit per cycle with
// the add-3 rule, then shifts them out one digit per cycle, top first.
// ----------------------------------------------------------------------------
module sida_dabble #(
  parameter int NDIG = sida_pkg::sida_num_digits(sida_pkg::VALUE_BITS_DEF)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sida_pkg::sida_ctl_t ctl_i,
  output logic [3:0]          top_digit_o
);
  import sida_pkg::*;

  localparam int BCD_W = 4 * NDIG;

  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic [BCD_W-1:0] adj;

  // Add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // Select clear, bit shift or digit drop
  always_comb begin
    bcd_d = bcd_q;
    if (ctl_i.clear) begin
      bcd_d = '0;
    end else if (ctl_i.dabble) begin
      bcd_d = {adj[BCD_W-2:0], ctl_i.bit_in};
    end else if (ctl_i.drop) begin
      bcd_d = {bcd_q[BCD_W-5:0], 4'd0};
    end
  end

  // Hold digits; cleared at reset and again at each new word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_q <= '0;
    end else begin
      bcd_q <= bcd_d;
    end
  end

  assign top_digit_o = bcd_q[BCD_W-1 -: 4];

endmodule

>>> hw/rtl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed integer to its decimal ASCII text, most significant
// character first, with a leading '-' for negative values.
// Output: '-' appears in the cycle after start for negative values; the first
// digit follows the bit-serial conversion of all VALUE_BITS bits, after any
// leading zeros are dropped unstrobed; digits then follow one per cycle.
// A new word is taken only when idle: busy holds through the bit-serial BCD
// conversion and the one-digit-per-cycle output.
// Reset clears the sequencer and the output strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  valid_o,
  output logic [7:0]            character_o,
  output logic                  last_o
);
  import sida_pkg::*;

  localparam int NDIG  = sida_num_digits(VALUE_BITS);
  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int REM_W = $clog2(NDIG + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic                  started_q, started_d;
  logic                  valid_q, valid_d;
  logic [7:0]            char_q, char_d;
  logic                  last_q, last_d;
  logic                  accept;
  logic [3:0]            top_digit;
  sida_ctl_t             ctl;

  assign accept = start && (state_q == ST_IDLE);

  sida_dabble #(
    .NDIG (NDIG)
  ) u_dabble (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .top_digit_o (top_digit)
  );

  // Sequence: load magnitude and emit any sign, shift bits in, skip leading zeros, emit digits
  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    started_d = started_q;
    valid_d   = 1'b0;
    char_d    = char_q;
    last_d    = last_q;
    ctl       = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (value_i[VALUE_BITS-1]) begin
            mag_d = ~value_i + {{(VALUE_BITS-1){1'b0}}, 1'b1};
          end else begin
            mag_d = value_i;
          end
          // Emit the sign word at once when the value is negative
          valid_d   = value_i[VALUE_BITS-1];
          char_d    = CHAR_MINUS;
          last_d    = 1'b0;
          cnt_d     = CNT_W'(VALUE_BITS);
          started_d = 1'b0;
          ctl.clear = 1'b1;
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        ctl.dabble = 1'b1;
        ctl.bit_in = mag_q[VALUE_BITS-1];
        mag_d      = {mag_q[VALUE_BITS-2:0], 1'b0};
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          rem_d   = REM_W'(NDIG);
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        ctl.drop = 1'b1;
        rem_d    = rem_q - 1'b1;
        if (started_q || (top_digit != 4'd0) || (rem_q == REM_W'(1))) begin
          valid_d   = 1'b1;
          char_d    = {CHAR_ZERO[7:4], top_digit};
          last_d    = (rem_q == REM_W'(1));
          started_d = 1'b1;
        end
        if (rem_q == REM_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rem_q     <= '0;
      started_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rem_q     <= rem_d;
      started_q <= started_d;
      valid_q   <= valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign valid_o     = valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  // The final word leaves once the sequencer is idle again
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |-> !busy)
    else $error("last word while busy");

  // An accepted start always begins a conversion
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("start accepted but not busy");

  // The sign is never the final character
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (character_o == CHAR_MINUS) |-> !last_o)
    else $error("sign flagged last");

  // No word leaves while bits are still being converted, except the sign
  a_conv_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (state_q == ST_CONV) |-> (character_o == CHAR_MINUS))
    else $error("digit emitted during conversion");

endmodule

>>> bench/signed_int_to_decimal_ascii_test.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test
// Self-checking bench for the signed integer to decimal ASCII converter.
// Sends words through the start/busy handshake with random gaps. A predictor
// turns each accepted word into its expected characters. A checker compares
// every strobed character and last flag against them, in order.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_test;

  import sida_pkg::*;

  localparam int WIDTH      = VALUE_BITS_DEF;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN      = 80;
  localparam int RANDOM_WORDS = 200;

  typedef struct {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic [WIDTH-1:0] value_i = '0;
  logic             busy;
  logic             valid_o;
  logic [7:0]       character_o;
  logic             last_o;

  text_char_t expected_text[$];
  int         mismatches = 0;
  int         idle_cycles = 0;

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(WIDTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .value_i    (value_i),
    .valid_o    (valid_o),
    .character_o(character_o),
    .last_o     (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Append the decimal text of one word, sign first, digits most significant first
  task automatic predict_decimal_text(input logic [WIDTH-1:0] word);
    logic [WIDTH-1:0] magnitude;
    logic [7:0]       digits[20];
    int               count;
    text_char_t       entry;
    magnitude = word[WIDTH-1] ? (~word + 1'b1) : word;
    count = 0;
    do begin
      digits[count] = CHAR_ZERO + 8'(magnitude % 10);
      magnitude = magnitude / 10;
      count++;
    end while (magnitude != 0);
    if (word[WIDTH-1]) begin
      entry.character = CHAR_MINUS;
      entry.last = 1'b0;
      expected_text.push_back(entry);
    end
    for (int k = count - 1; k >= 0; k--) begin
      entry.character = digits[k];
      entry.last = (k == 0);
      expected_text.push_back(entry);
    end
  endtask

  // Wait a random gap, then hold start until the word is taken
  task automatic send_word(input logic [WIDTH-1:0] word);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    value_i <= word;
    do @(posedge clk_i); while (busy);
    predict_decimal_text(word);
  endtask

  // Draw a value with a random digit count and sign, now and then fully random
  function automatic logic [WIDTH-1:0] random_word();
    logic [WIDTH-1:0] low_mag;
    logic [WIDTH-1:0] high_mag;
    logic [WIDTH-1:0] magnitude;
    int               ndigits;
    if ($urandom_range(0, 3) == 0) begin
      return $urandom();
    end
    ndigits = $urandom_range(1, 10);
    low_mag = 1;
    repeat (ndigits - 1) low_mag = low_mag * 10;
    high_mag = (ndigits == 10) ? 32'h7FFF_FFFF : low_mag * 10 - 1;
    if (ndigits == 1) begin
      low_mag = 0;
    end
    magnitude = $urandom_range(high_mag, low_mag);
    return $urandom_range(0, 1) ? (~magnitude + 1'b1) : magnitude;
  endfunction

  // Zero, the ends of the range, single digits and alternating bit patterns
  task automatic test_extremes();
    send_word(32'd0);
    send_word(32'd1);
    send_word(-32'sd1);
    send_word(32'd9);
    send_word(-32'sd9);
    send_word(32'h7FFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'h8000_0001);
    send_word(32'h5555_5555);
    send_word(32'hAAAA_AAAA);
  endtask

  // Digit count changes: powers of ten and one below, both signs
  task automatic test_digit_boundaries();
    send_word(32'd10);
    send_word(-32'sd10);
    send_word(32'd99);
    send_word(32'd100);
    send_word(-32'sd999);
    send_word(32'd1_000_000_000);
    send_word(-32'sd1_000_000_000);
    send_word(32'd999_999_999);
    send_word(-32'sd999_999_999);
    send_word(32'd1_999_999_999);
  endtask

  // Random words, back to back or spread out
  task automatic test_random_words();
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      send_word(random_word());
    end
  endtask

  // Compare each strobed character with the oldest expected one
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && valid_o) begin
      if (expected_text.size() == 0) begin
        $error("character: unexpected word %0d with last %0d", character_o, last_o);
        mismatches++;
      end else begin
        want = expected_text.pop_front();
        if (character_o !== want.character) begin
          $error("character: expected %0d, got %0d", want.character, character_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          mismatches++;
        end
      end
    end
  end

  // Count cycles with no handshake on either side and stop a hung run
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[signed_int_to_decimal_ascii] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_digit_boundaries();
    test_random_words();
    start <= 1'b0;
    // drain outstanding characters, then watch for strays
    while (expected_text.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[signed_int_to_decimal_ascii] OK");
    end else begin
      $display("[signed_int_to_decimal_ascii] ERROR");
    end
    $finish;
  end

endmodule
